// File: rtl/fir_convolver_with_flush_top_defines.svh
// Shared assertion macros. Each expects clk and rst_n in scope.
`ifndef FIR_CONVOLVER_WITH_FLUSH_TOP_DEFINES_SVH
`define FIR_CONVOLVER_WITH_FLUSH_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define FCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define FCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fcf_pkg.sv
package fcf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int OP_W        = 2;
  localparam int TAP_INDEX_W = 6;
  localparam int TAP_COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]               operation;
    logic [TAP_INDEX_W-1:0]        tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          saturated;
    logic                          last;
  } out_item_t;

  // command after classification; same layout as the input item
  typedef struct packed {
    logic [OP_W-1:0]               op;
    logic [TAP_INDEX_W-1:0]        tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
  } cmd_t;

endpackage

// File: rtl/fcf_ram.sv
module fcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fcf_front.sv
module fcf_front #(
  parameter int MAX_TAPS = 64
) (
  input  logic              in_valid,
  input  fcf_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              in_stall,
  output logic              enq,
  output fcf_pkg::cmd_t     cmd
);

  logic keep;

  // nop codes and loads past the tap store are taken and dropped here
  always_comb begin
    keep = 1'b0;
    unique case (in_data.operation)
      fcf_pkg::OP_LOAD:  keep = {1'b0, in_data.tap_index} <
                                fcf_pkg::TAP_COUNT_W'(MAX_TAPS);
      fcf_pkg::OP_PUSH:  keep = 1'b1;
      fcf_pkg::OP_FLUSH: keep = 1'b1;
      default:           keep = 1'b0;
    endcase
  end

  assign in_stall      = q_full;
  assign enq           = in_valid && !q_full && keep;
  assign cmd.op        = in_data.operation;
  assign cmd.tap_index = in_data.tap_index;
  assign cmd.value     = in_data.value;

endmodule

// File: rtl/fcf_queue.sv
module fcf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fcf_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output fcf_pkg::cmd_t pop_data
);

  fcf_pkg::cmd_t ent_r [2];
  logic          wptr_r, wptr_nxt;
  logic          rptr_r, rptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_pop;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign pop_data  = ent_r[rptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wptr_nxt  = push   ? ~wptr_r : wptr_r;
    rptr_nxt  = do_pop ? ~rptr_r : rptr_r;
    count_nxt = count_r;
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/fcf_back.sv
`include "fir_convolver_with_flush_top_defines.svh"

module fcf_back #(
  parameter int MAX_TAPS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [fcf_pkg::TAP_COUNT_W-1:0]   tap_count,
  input  logic                              q_valid,
  input  fcf_pkg::cmd_t                     q_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fcf_pkg::out_item_t                out_data
);

  localparam int SB    = fcf_pkg::SAMPLE_BITS;
  localparam int FB    = fcf_pkg::FRAC_BITS;
  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int PW    = 2 * SB;
  localparam int ACC_W = PW + $clog2(MAX_TAPS) + 1;
  localparam int RW    = ACC_W - FB;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(2 ** (FB - 1));

  logic [1:0]                state_r, state_nxt;
  logic [AW-1:0]             head_r, head_nxt;
  logic [MAX_TAPS-1:0]       hvalid_r, hvalid_nxt;
  logic                      is_flush_r, is_flush_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic [AW-1:0]             k_r, k_nxt;
  logic [AW-1:0]             np_r, np_nxt;
  logic [AW-1:0]             tptr_r, tptr_nxt;
  logic [AW-1:0]             hptr_r, hptr_nxt;
  logic [CW-1:0]             left_r, left_nxt;
  logic                      rd_v_r, rd_v_nxt;
  logic                      rd_last_r, rd_last_nxt;
  logic                      hv_d_r, hv_d_nxt;
  logic                      prod_v_r, prod_v_nxt;
  logic                      prod_last_r, prod_last_nxt;
  logic signed [PW-1:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  fcf_pkg::out_item_t        out_data_r, out_data_nxt;

  logic [CW-1:0]             n_eff;
  logic                      issue;
  logic                      out_free;
  logic [CW-1:0]             kp1;
  logic [AW-1:0]             head_dec;
  logic [AW-1:0]             head_inc;
  logic                      tap_we, hist_we;
  logic signed [SB-1:0]      tap_rdata, hist_rdata, hist_op;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic [RW-1:0]             rsh;
  logic                      clip;
  logic                      fin_done;

  fcf_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (q_cmd.tap_index[AW-1:0]),
    .wdata (q_cmd.value),
    .raddr (tptr_r),
    .rdata (tap_rdata)
  );

  fcf_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_r),
    .wdata (q_cmd.value),
    .raddr (hptr_r),
    .rdata (hist_rdata)
  );

  always_comb begin
    if (tap_count == '0) begin
      n_eff = CW'(1);
    end else if (tap_count > fcf_pkg::TAP_COUNT_W'(MAX_TAPS)) begin
      n_eff = CW'(MAX_TAPS);
    end else begin
      n_eff = CW'(tap_count);
    end
  end

  assign head_dec = (head_r == '0) ? AW'(MAX_TAPS - 1) : head_r - 1'b1;
  assign head_inc = (head_r == AW'(MAX_TAPS - 1)) ? '0 : head_r + 1'b1;
  assign issue    = (state_r == ST_MAC) && (left_r != '0);
  assign out_free = !out_valid_r || !out_stall;
  assign kp1      = CW'(k_r) + CW'(1);
  assign fin_done = (state_r == ST_FIN) && out_free && !(is_flush_r && kp1 != n_r);

  // slots never written since reset or the last flush read as zero
  assign hist_op  = hv_d_r ? hist_rdata : '0;
  assign prod_nxt = tap_rdata * hist_op;

  // round half up, then clip to the sample range
  assign rnd_sum = acc_r + RND;
  assign rsh     = rnd_sum[ACC_W-1:FB];
  assign clip    = !((&rsh[RW-1:SB-1]) || !(|rsh[RW-1:SB-1]));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    hvalid_nxt    = hvalid_r;
    is_flush_nxt  = is_flush_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    np_nxt        = np_r;
    tptr_nxt      = tptr_r;
    hptr_nxt      = hptr_r;
    left_nxt      = left_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    tap_we        = 1'b0;
    hist_we       = 1'b0;

    rd_v_nxt      = issue;
    rd_last_nxt   = issue && (left_r == CW'(1));
    hv_d_nxt      = hvalid_r[hptr_r];
    prod_v_nxt    = rd_v_r;
    prod_last_nxt = rd_last_r;

    if (issue) begin
      tptr_nxt = tptr_r + 1'b1;
      hptr_nxt = (hptr_r == '0) ? AW'(MAX_TAPS - 1) : hptr_r - 1'b1;
      left_nxt = left_r - CW'(1);
    end
    if (prod_v_r) begin
      acc_nxt = acc_r + {{(ACC_W - PW){prod_r[PW-1]}}, prod_r};
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            fcf_pkg::OP_LOAD: begin
              tap_we = 1'b1;
            end
            fcf_pkg::OP_PUSH: begin
              hist_we            = 1'b1;
              hvalid_nxt[head_r] = 1'b1;
              head_nxt           = head_inc;
              is_flush_nxt       = 1'b0;
              n_nxt              = n_eff;
              k_nxt              = '0;
              np_nxt             = head_r;
              tptr_nxt           = '0;
              hptr_nxt           = head_r;
              left_nxt           = n_eff;
              acc_nxt            = '0;
              state_nxt          = ST_MAC;
            end
            fcf_pkg::OP_FLUSH: begin
              if (n_eff == CW'(1)) begin
                hvalid_nxt = '0;
                head_nxt   = '0;
              end else begin
                is_flush_nxt = 1'b1;
                n_nxt        = n_eff;
                k_nxt        = AW'(1);
                np_nxt       = head_dec;
                tptr_nxt     = AW'(1);
                hptr_nxt     = head_dec;
                left_nxt     = n_eff - CW'(1);
                acc_nxt      = '0;
                state_nxt    = ST_MAC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        if (prod_v_r && prod_last_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_sample = clip ? {rsh[RW-1], {(SB - 1){!rsh[RW-1]}}}
                                         : rsh[SB-1:0];
          out_data_nxt.saturated  = clip;
          out_data_nxt.last       = !is_flush_r || (kp1 == n_r);
          if (is_flush_r && kp1 != n_r) begin
            k_nxt     = AW'(kp1);
            tptr_nxt  = AW'(kp1);
            hptr_nxt  = np_r;
            left_nxt  = n_r - kp1;
            acc_nxt   = '0;
            state_nxt = ST_MAC;
          end else begin
            if (is_flush_r) begin
              hvalid_nxt = '0;
              head_nxt   = '0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      hvalid_r    <= '0;
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      prod_v_r    <= 1'b0;
      prod_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      hvalid_r    <= hvalid_nxt;
      rd_v_r      <= rd_v_nxt;
      rd_last_r   <= rd_last_nxt;
      prod_v_r    <= prod_v_nxt;
      prod_last_r <= prod_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_flush_r <= is_flush_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    np_r       <= np_nxt;
    tptr_r     <= tptr_nxt;
    hptr_r     <= hptr_nxt;
    left_r     <= left_nxt;
    hv_d_r     <= hv_d_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FCF_ASSERT_NOW(a_prod_in_mac, prod_v_r || rd_v_r, state_r == ST_MAC, "MAC pipeline active outside MAC state")
  `FCF_ASSERT_NOW(a_mac_no_hang, state_r == ST_MAC && left_r == '0, rd_v_r || prod_v_r, "MAC state with nothing in flight")
  `FCF_ASSERT_NEXT(a_fin_waits, state_r == ST_FIN && out_valid_r && out_stall, state_r == ST_FIN, "result dropped while output stalled")
  `FCF_ASSERT_NEXT(a_flush_clears, fin_done && is_flush_r, head_r == '0 && hvalid_r == '0, "history not cleared after flush tail")

endmodule

// File: rtl/fir_convolver_with_flush_top.sv
// FIR convolver with tail flush, Q1.15 samples and taps.
// Input channel (in_valid/in_stall/in_data): an item loads one tap, pushes one
// sample or flushes the tail; a transfer happens when valid is high and stall low.
// Items pass through a two-entry command queue to the MAC engine, so the input
// keeps taking items while the engine works or a result waits.
// Output channel (out_valid/out_stall/out_data): one registered result; while the
// receiver stalls, the engine holds its finished sum and the queue fills, then
// in_stall rises.
// Engine, n = taps in use: a load writes one tap and leaves the engine idle; a
// push gives one result and holds the engine until that result is registered,
// the engine doing one tap MAC per cycle (set by the single multiplier and
// the one read port of each tap and history RAM). A flush gives n - 1 results,
// which the engine works out one after another.
// tap_count sits at APB byte address 0; write it only while no item is in flight.
// Reset: tap_count = 1, history reads as zero, queue and output empty. Tap
// coefficients are undefined until loaded.
module fir_convolver_with_flush_top #(
  parameter int MAX_TAPS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fcf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fcf_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [fcf_pkg::TAP_COUNT_W-1:0] tap_count_r, tap_count_nxt;
  logic                            q_full, enq, q_valid, q_pop;
  fcf_pkg::cmd_t                   enq_cmd, q_cmd;
  logic                            cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2] == 1'b0;
  assign cfg_prdata = cfg_sel ? {{(32 - fcf_pkg::TAP_COUNT_W){1'b0}}, tap_count_r} : '0;

  always_comb begin
    tap_count_nxt = tap_count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel) begin
      tap_count_nxt = cfg_pwdata[fcf_pkg::TAP_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= fcf_pkg::TAP_COUNT_W'(1);
    end else begin
      tap_count_r <= tap_count_nxt;
    end
  end

  fcf_front #(.MAX_TAPS(MAX_TAPS)) u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .enq      (enq),
    .cmd      (enq_cmd)
  );

  fcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (enq),
    .push_data (enq_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_cmd)
  );

  fcf_back #(.MAX_TAPS(MAX_TAPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap_count (tap_count_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: dv/tb_fir_convolver_with_flush_top.sv
module tb_fir_convolver_with_flush_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = fcf_pkg::SAMPLE_BITS;
  localparam int TIW = fcf_pkg::TAP_INDEX_W;
  localparam int TCW = fcf_pkg::TAP_COUNT_W;
  localparam int MAX_TAPS = 64;
  localparam logic [fcf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] TAP_COUNT_ADDR = 3'd0;
  localparam logic signed [SB-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [SB-1:0] Q_MIN = 16'sh8000;
  localparam longint SMAX = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  // covers queued loads still in the engine and a full-length result
  localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 16;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  fcf_pkg::in_item_t    in_data;
  logic                 out_valid;
  logic                 out_stall;
  fcf_pkg::out_item_t   out_data;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [2:0]           cfg_paddr;
  logic [31:0]          cfg_pwdata;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  fir_convolver_with_flush_top #(.MAX_TAPS(MAX_TAPS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // filter state as the testbench sees it
  logic signed [SB-1:0] coef [MAX_TAPS];
  logic signed [SB-1:0] hist [MAX_TAPS];
  logic [TIW-1:0]       head;
  logic [TCW-1:0]       tap_count_reg;

  fcf_pkg::out_item_t fir_out_due[$];
  fcf_pkg::out_item_t want;
  int                 err_count;
  int unsigned        cycle_count;
  bit                 idle_enabled;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int taps_active();
    if (tap_count_reg == 0) return 1;
    if (tap_count_reg > MAX_TAPS) return MAX_TAPS;
    return int'(tap_count_reg);
  endfunction

  // history slot holding the sample 'age' steps older than the newest
  function automatic logic [TIW-1:0] hist_slot(int age);
    return TIW'(head - 1 - age);
  endfunction

  function automatic fcf_pkg::out_item_t round_sat(longint acc, bit is_last);
    longint             r;
    fcf_pkg::out_item_t o;
    // arithmetic shift of a signed value is a floor
    r = (acc + (longint'(1) <<< (fcf_pkg::FRAC_BITS - 1))) >>> fcf_pkg::FRAC_BITS;
    o.saturated = 1'b0;
    if (r > SMAX) begin
      r = SMAX;
      o.saturated = 1'b1;
    end
    if (r < SMIN) begin
      r = SMIN;
      o.saturated = 1'b1;
    end
    o.out_sample = r[SB-1:0];
    o.last = is_last;
    return o;
  endfunction

  task automatic convolve_item(input fcf_pkg::in_item_t it);
    int     n;
    longint acc;
    n = taps_active();
    case (it.operation)
      fcf_pkg::OP_LOAD: coef[it.tap_index] = it.value;
      fcf_pkg::OP_PUSH: begin
        hist[head] = it.value;
        head = head + 1'b1;
        acc = 0;
        for (int j = 0; j < n; j++)
          acc += longint'(coef[j]) * longint'(hist[hist_slot(j)]);
        fir_out_due.push_back(round_sat(acc, 1'b1));
      end
      fcf_pkg::OP_FLUSH: begin
        // tail: the outputs that zeros pushed after the last sample would give
        for (int k = 1; k < n; k++) begin
          acc = 0;
          for (int j = k; j < n; j++)
            acc += longint'(coef[j]) * longint'(hist[hist_slot(j - k)]);
          fir_out_due.push_back(round_sat(acc, k == n - 1));
        end
        foreach (hist[i]) hist[i] = '0;
        head = '0;
      end
      default: ;
    endcase
  endtask

  function automatic fcf_pkg::in_item_t make_item(logic [fcf_pkg::OP_W-1:0] op, int idx,
                                                  logic signed [SB-1:0] val);
    fcf_pkg::in_item_t it;
    it.operation = op;
    it.tap_index = TIW'(idx);
    it.value = val;
    return it;
  endfunction

  function automatic logic signed [SB-1:0] pick_q15();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return SB'(int'($urandom_range(0, 127)) - 64);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic fcf_pkg::in_item_t pick_item();
    int                        r;
    logic [fcf_pkg::OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 15) op = fcf_pkg::OP_LOAD;
    else if (r < 85) op = fcf_pkg::OP_PUSH;
    else if (r < 95) op = fcf_pkg::OP_FLUSH;
    else op = OP_UNUSED;
    return make_item(op, $urandom_range(0, MAX_TAPS - 1), pick_q15());
  endfunction

  // one transfer on the input channel; valid stays high on return
  task automatic send_item(input fcf_pkg::in_item_t it);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    convolve_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (fir_out_due.size() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves psel high so a second access can follow back to back
  task automatic apb_access(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= TAP_COUNT_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  task automatic read_tap_count_check();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== 32'(tap_count_reg)) begin
      err_count++;
      $display("%0t: tap_count readback expected %0d got %0d", $time, tap_count_reg, rd);
    end
  endtask

  task automatic set_tap_count(input logic [TCW-1:0] cnt);
    logic [31:0] rd;
    apb_access(1'b1, 32'(cnt), rd);
    tap_count_reg = cnt;
    read_tap_count_check();
  endtask

  task automatic run_random_items(input int count, input bit pressure);
    for (int i = 0; i < count; i++) begin
      if (pressure && i == count / 2) wait_drained();
      send_item(pick_item());
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (fir_out_due.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: sample %0d sat %0b last %0b", $time,
                 out_data.out_sample, out_data.saturated, out_data.last);
      end else begin
        want = fir_out_due.pop_front();
        if (out_data !== want) begin
          err_count++;
          $display("%0t: result mismatch: expected sample %0d sat %0b last %0b,",
                   $time, want.out_sample, want.saturated, want.last,
                   " got sample %0d sat %0b last %0b",
                   out_data.out_sample, out_data.saturated, out_data.last);
        end
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_reset_value();
    read_tap_count_check();
  endtask

  task automatic test_single_tap();
    send_item(make_item(fcf_pkg::OP_LOAD, 0, Q_MAX));
    send_item(make_item(fcf_pkg::OP_PUSH, 0, Q_MAX));
    send_item(make_item(fcf_pkg::OP_PUSH, 63, Q_MIN));
    send_item(make_item(fcf_pkg::OP_LOAD, 0, Q_MIN));
    // most negative times most negative clips high
    send_item(make_item(fcf_pkg::OP_PUSH, 0, Q_MIN));
    send_item(make_item(fcf_pkg::OP_PUSH, 0, Q_MAX));
    send_item(make_item(fcf_pkg::OP_PUSH, 0, 16'sd1));
    // one tap: flush gives nothing but clears history
    send_item(make_item(fcf_pkg::OP_FLUSH, 0, 16'sd0));
    send_item(make_item(OP_UNUSED, 42, 16'sh5A5A));
  endtask

  task automatic test_three_taps();
    send_item(make_item(fcf_pkg::OP_LOAD, 1, Q_MIN));
    send_item(make_item(fcf_pkg::OP_LOAD, 2, 16'sd12345));
    send_item(make_item(fcf_pkg::OP_LOAD, 63, -16'sd1));
    settle();
    set_tap_count(7'd3);
    send_item(make_item(fcf_pkg::OP_PUSH, 0, Q_MAX));
    send_item(make_item(fcf_pkg::OP_PUSH, 0, Q_MAX));
    send_item(make_item(fcf_pkg::OP_PUSH, 0, Q_MIN));
    send_item(make_item(fcf_pkg::OP_PUSH, 0, -16'sd1));
    send_item(make_item(fcf_pkg::OP_FLUSH, 0, 16'sd0));
    send_item(make_item(fcf_pkg::OP_PUSH, 0, 16'sd100));
  endtask

  task automatic test_zero_tap_count();
    settle();
    set_tap_count(7'd0);
    send_item(make_item(fcf_pkg::OP_PUSH, 0, Q_MIN));
    send_item(make_item(fcf_pkg::OP_PUSH, 0, 16'sd5));
    send_item(make_item(fcf_pkg::OP_FLUSH, 0, 16'sd0));
  endtask

  task automatic test_long_filter();
    for (int i = 0; i < MAX_TAPS; i++) send_item(make_item(fcf_pkg::OP_LOAD, i, pick_q15()));
    settle();
    set_tap_count(7'd64);
    run_random_items(16, 1'b1);
    send_item(make_item(fcf_pkg::OP_FLUSH, 0, 16'sd0));
    settle();
    // above the tap limit acts as the limit
    set_tap_count(7'd127);
    run_random_items(12, 1'b0);
  endtask

  task automatic test_random_stream();
    settle();
    set_tap_count(TCW'($urandom_range(2, 8)));
    run_random_items(20, 1'b1);
    settle();
    set_tap_count(TCW'($urandom_range(9, 24)));
    run_random_items(12, 1'b0);
  endtask

  task automatic test_no_idle();
    settle();
    idle_enabled = 1'b0;
    set_tap_count(TCW'($urandom_range(1, 6)));
    run_random_items(16, 1'b0);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    err_count = 0;
    idle_enabled = 1'b0;
    foreach (coef[i]) coef[i] = '0;
    foreach (hist[i]) hist[i] = '0;
    head = '0;
    tap_count_reg = 7'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    idle_enabled = 1'b1;

    test_reset_value();
    test_single_tap();
    test_three_taps();
    test_zero_tap_count();
    test_long_filter();
    test_random_stream();
    test_no_idle();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: fir_convolver_with_flush_top.f
+incdir+rtl
rtl/fcf_pkg.sv
rtl/fcf_ram.sv
rtl/fcf_front.sv
rtl/fcf_queue.sv
rtl/fcf_back.sv
rtl/fir_convolver_with_flush_top.sv
dv/tb_fir_convolver_with_flush_top.sv
